// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLKED(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/core/r6tb_pkg.sv -----
// ----------------------------------------------------------------------------
// r6tb_pkg
// Shared constants, operation codes and types of the radix-6 butterfly.
// ----------------------------------------------------------------------------
`default_nettype none

package r6tb_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int OUT_WIDTH      = 28;
    localparam int IDX_WIDTH      = 3;
    localparam int COEF_MIN_WIDTH = 18;
    localparam int K3_COEF        = 56756;
    localparam int ONE_COEF       = 65536;

    localparam logic [IDX_WIDTH-1:0] LAST_INDEX = 3'd5;

    typedef logic [2:0] t_op;

    // Operations of the shared multiplier, in issue order
    localparam t_op OP_K3A = 3'd0;
    localparam t_op OP_K3B = 3'd1;
    localparam t_op OP_X0  = 3'd2;
    localparam t_op OP_X1  = 3'd3;
    localparam t_op OP_X2  = 3'd4;
    localparam t_op OP_X3  = 3'd5;
    localparam t_op OP_X4  = 3'd6;
    localparam t_op OP_X5  = 3'd7;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_mul_tag;

    function automatic logic is_k3(input t_op op);
        return (op == OP_K3A) || (op == OP_K3B);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/r6tb_cmul.sv -----
// ----------------------------------------------------------------------------
// r6tb_cmul
// Shared complex multiplier: registered partial products, then one
// round-half-up shift and a saturation to the output width.
// ----------------------------------------------------------------------------
`default_nettype none

module r6tb_cmul #(
    parameter int DW = 29,
    parameter int CW = 18
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire r6tb_pkg::t_mul_tag                       i_issue,
    input  wire logic signed [DW-1:0]                     i_opa,
    input  wire logic signed [DW-1:0]                     i_opb,
    input  wire logic signed [CW-1:0]                     i_wr,
    input  wire logic signed [CW-1:0]                     i_wi,
    input  wire logic                                     i_take,
    output r6tb_pkg::t_mul_tag                            o_tag,
    output logic signed [DW-1:0]                          o_short_re,
    output logic signed [DW-1:0]                          o_short_im,
    output logic signed [r6tb_pkg::OUT_WIDTH-1:0]         o_sat_re,
    output logic signed [r6tb_pkg::OUT_WIDTH-1:0]         o_sat_im
);

    localparam int OW   = r6tb_pkg::OUT_WIDTH;
    localparam int FB   = r6tb_pkg::FRAC_BITS;
    localparam int PW   = DW + CW;
    localparam int SUMW = PW + 1;
    localparam int RW   = SUMW - FB;
    localparam int EW   = (RW > OW) ? RW : OW + 1;

    localparam logic signed [SUMW-1:0] BIAS = SUMW'(1) <<< (FB - 1);

    r6tb_pkg::t_mul_tag      r_tag;
    logic signed [PW-1:0]    r_a_wr;
    logic signed [PW-1:0]    r_b_wi;
    logic signed [PW-1:0]    r_a_wi;
    logic signed [PW-1:0]    r_b_wr;

    logic signed [SUMW-1:0]  sum_re;
    logic signed [SUMW-1:0]  sum_im;
    logic signed [SUMW-1:0]  bias_re;
    logic signed [SUMW-1:0]  bias_im;
    logic signed [RW-1:0]    rnd_re;
    logic signed [RW-1:0]    rnd_im;

    function automatic logic [OW-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [EW-1:0] ext;
        logic                 all_ones;
        logic                 all_zeros;
        ext       = EW'(v);
        all_ones  = &ext[EW-1:OW-1];
        all_zeros = ~|ext[EW-1:OW-1];
        if (all_ones || all_zeros) begin
            return ext[OW-1:0];
        end else if (ext[EW-1]) begin
            return {1'b1, {(OW-1){1'b0}}};
        end else begin
            return {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_issue.valid) begin
            r_tag <= i_issue;
        end else if (i_take) begin
            r_tag.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue.valid) begin
            r_a_wr <= i_opa * i_wr;
            r_b_wi <= i_opb * i_wi;
            r_a_wi <= i_opa * i_wi;
            r_b_wr <= i_opb * i_wr;
        end
    end

    always_comb begin
        sum_re  = SUMW'(r_a_wr) - SUMW'(r_b_wi);
        sum_im  = SUMW'(r_a_wi) + SUMW'(r_b_wr);
        bias_re = sum_re + BIAS;
        bias_im = sum_im + BIAS;
        // floor shift: keep the upper bits
        rnd_re  = $signed(bias_re[SUMW-1:FB]);
        rnd_im  = $signed(bias_im[SUMW-1:FB]);
    end

    assign o_tag      = r_tag;
    assign o_short_re = rnd_re[DW-1:0];
    assign o_short_im = rnd_im[DW-1:0];
    assign o_sat_re   = $signed(sat(rnd_re));
    assign o_sat_im   = $signed(sat(rnd_im));

endmodule

`default_nettype wire

// ----- rtl/core/r6tb_bfly.sv -----
// ----------------------------------------------------------------------------
// r6tb_bfly
// Radix-6 butterfly adder network: registered partial sums, stored
// sqrt3/2 products, and the operand select for the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module r6tb_bfly #(
    parameter int SW = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic [5:0][SW:0]      i_xr,
    input  wire logic [5:0][SW:0]      i_xi,
    input  wire r6tb_pkg::t_mul_tag    i_k3_tag,
    input  wire logic signed [SW+4:0]  i_k3_re,
    input  wire logic signed [SW+4:0]  i_k3_im,
    input  wire r6tb_pkg::t_op         i_op,
    output logic signed [SW+4:0]       o_opa,
    output logic signed [SW+4:0]       o_opb
);

    localparam int DW = SW + 5;

    logic signed [DW-1:0] xr [6];
    logic signed [DW-1:0] xi [6];
    logic signed [DW-1:0] a2r, a2i, a3r, a3i;

    logic signed [DW-1:0] r_a1r, r_a1i, r_a4r, r_a4i;
    logic signed [DW-1:0] r_a5r, r_a5i, r_a6r, r_a6i;
    logic signed [DW-1:0] r_a7r, r_a7i, r_a8r, r_a8i;
    logic signed [DW-1:0] r_t1i, r_t2r, r_u1i, r_u2r;

    logic signed [DW-1:0] t1r, t2i, u1r, u2i;

    function automatic logic signed [DW-1:0] half(input logic signed [DW-1:0] v);
        return (v + $signed(DW'(1))) >>> 1;
    endfunction

    always_comb begin
        for (int n = 0; n < 6; n++) begin
            xr[n] = DW'($signed(i_xr[n]));
            xi[n] = DW'($signed(i_xi[n]));
        end
        a2r = xr[1] + xr[5];
        a2i = xi[1] + xi[5];
        a3r = xr[2] + xr[4];
        a3i = xi[2] + xi[4];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a1r <= xr[0] + xr[3];
            r_a1i <= xi[0] + xi[3];
            r_a4r <= xr[0] - xr[3];
            r_a4i <= xi[0] - xi[3];
            r_a5r <= xr[1] - xr[5];
            r_a5i <= xi[1] - xi[5];
            r_a6r <= xr[2] - xr[4];
            r_a6i <= xi[2] - xi[4];
            r_a7r <= a3r - a2r;
            r_a7i <= a3i - a2i;
            r_a8r <= a3r + a2r;
            r_a8i <= a3i + a2i;
        end
    end

    // Hold the sqrt3/2 products used by outputs 1, 2, 4 and 5
    always_ff @(posedge i_clk) begin
        if (i_k3_tag.valid && (i_k3_tag.op == r6tb_pkg::OP_K3A)) begin
            r_t1i <= i_k3_re;
            r_t2r <= i_k3_im;
        end
        if (i_k3_tag.valid && (i_k3_tag.op == r6tb_pkg::OP_K3B)) begin
            r_u1i <= i_k3_re;
            r_u2r <= i_k3_im;
        end
    end

    always_comb begin
        t1r = r_a4r - half(r_a7r);
        t2i = r_a4i - half(r_a7i);
        u1r = r_a1r - half(r_a8r);
        u2i = r_a1i - half(r_a8i);
    end

    always_comb begin
        unique case (i_op)
            r6tb_pkg::OP_K3A: begin
                o_opa = r_a5i + r_a6i;
                o_opb = r_a6r + r_a5r;
            end
            r6tb_pkg::OP_K3B: begin
                o_opa = r_a5i - r_a6i;
                o_opb = r_a6r - r_a5r;
            end
            r6tb_pkg::OP_X0: begin
                o_opa = r_a1r + r_a8r;
                o_opb = r_a1i + r_a8i;
            end
            r6tb_pkg::OP_X1: begin
                o_opa = t1r - r_t1i;
                o_opb = t2i + r_t2r;
            end
            r6tb_pkg::OP_X2: begin
                o_opa = u1r - r_u1i;
                o_opb = u2i - r_u2r;
            end
            r6tb_pkg::OP_X3: begin
                o_opa = r_a4r + r_a7r;
                o_opb = r_a4i + r_a7i;
            end
            r6tb_pkg::OP_X4: begin
                o_opa = u1r + r_u1i;
                o_opb = u2i + r_u2r;
            end
            r6tb_pkg::OP_X5: begin
                o_opa = t1r + r_t1i;
                o_opb = t2i - r_t2r;
            end
            default: begin
                o_opa = '0;
                o_opb = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/radix6_c2r_twiddle_butterfly.sv -----
// ----------------------------------------------------------------------------
// radix6_c2r_twiddle_butterfly
// Fixed-point radix-6 butterfly with output twiddles for complex-to-real
// FFT passes, built around one shared complex multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   i_in_valid/o_in_stall   sample_real/imag, twiddle_real/imag
//  out      out  o_out_valid/i_out_stall o_bin_re/o_bin_im, out_index, last
//
//  Six input beats are taken one per cycle. The sixth beat starts the
//  butterfly state, then eight multiplier passes (two sqrt3/2 passes, six
//  outputs) issue one per cycle unless a stalled, full output register
//  holds them. o_in_stall is high from the sixth beat until X5 enters the
//  output register. An output stall holds the multiplier stage.
//  Reset clears the point counter, sequencer and valid flags, not the stores.
// ----------------------------------------------------------------------------
`default_nettype none

module radix6_c2r_twiddle_butterfly #(
    parameter int SAMPLE_WIDTH  = 24,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]           i_sample_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0]           i_sample_imag,
    input  wire logic signed [TWIDDLE_WIDTH-1:0]          i_twiddle_real,
    input  wire logic signed [TWIDDLE_WIDTH-1:0]          i_twiddle_imag,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [r6tb_pkg::OUT_WIDTH-1:0]         o_bin_re,
    output logic signed [r6tb_pkg::OUT_WIDTH-1:0]         o_bin_im,
    output logic [r6tb_pkg::IDX_WIDTH-1:0]                o_out_index,
    output logic                                          o_last
);

    localparam int XW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 5;
    localparam int CW = (TWIDDLE_WIDTH > r6tb_pkg::COEF_MIN_WIDTH) ?
                        TWIDDLE_WIDTH : r6tb_pkg::COEF_MIN_WIDTH;
    localparam int OW = r6tb_pkg::OUT_WIDTH;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_BFLY = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [2:0] CONJ_FIRST = 3'd3;
    localparam logic [2:0] LAST_POINT = 3'd5;

    logic [1:0]              r_state, n_state;
    logic [2:0]              r_cnt, n_cnt;
    r6tb_pkg::t_op           r_op, n_op;
    logic                    r_issuing, n_issuing;

    logic [5:0][XW-1:0]      r_xr;
    logic [5:0][XW-1:0]      r_xi;
    logic [TWIDDLE_WIDTH-1:0] r_twr [5];
    logic [TWIDDLE_WIDTH-1:0] r_twi [5];

    logic                    r_out_valid;
    logic signed [OW-1:0]    r_out_re;
    logic signed [OW-1:0]    r_out_im;
    logic [r6tb_pkg::IDX_WIDTH-1:0] r_out_idx;
    logic                    r_out_last;

    logic                    in_beat;
    logic                    out_beat;
    logic signed [XW-1:0]    cap_im;
    logic [2:0]              tw_wr_idx;
    logic [2:0]              tw_rd_idx;

    r6tb_pkg::t_mul_tag      issue;
    r6tb_pkg::t_mul_tag      mul_tag;
    r6tb_pkg::t_mul_tag      k3_tag;
    logic                    take;
    logic                    out_load;
    logic                    advance;

    logic signed [DW-1:0]    opa, opb;
    logic signed [CW-1:0]    coef_re, coef_im;
    logic signed [DW-1:0]    short_re, short_im;
    logic signed [OW-1:0]    sat_re, sat_im;

    assign o_in_stall = (r_state != ST_LOAD);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_beat   = r_out_valid && !i_out_stall;

    // Capture: conjugate points 3 to 5
    assign cap_im    = (r_cnt >= CONJ_FIRST) ? -XW'(i_sample_imag) : XW'(i_sample_imag);
    assign tw_wr_idx = r_cnt - 3'd1;

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_xr[r_cnt] <= XW'(i_sample_real);
            r_xi[r_cnt] <= cap_im;
            if (r_cnt != 3'd0) begin
                r_twr[tw_wr_idx] <= i_twiddle_real;
                r_twi[tw_wr_idx] <= i_twiddle_imag;
            end
        end
    end

    // Multiplier pipeline advances unless an output result finds the register full and stalled
    assign take     = mul_tag.valid &&
                      (r6tb_pkg::is_k3(mul_tag.op) || !r_out_valid || !i_out_stall);
    assign out_load = take && !r6tb_pkg::is_k3(mul_tag.op);
    assign advance  = (r_state == ST_EXEC) && r_issuing && (!mul_tag.valid || take);

    assign issue.valid  = advance;
    assign issue.op     = r_op;
    assign k3_tag.valid = take && r6tb_pkg::is_k3(mul_tag.op);
    assign k3_tag.op    = mul_tag.op;

    assign tw_rd_idx = r_op - r6tb_pkg::OP_X1;

    always_comb begin
        unique case (r_op)
            r6tb_pkg::OP_K3A, r6tb_pkg::OP_K3B: begin
                coef_re = CW'(r6tb_pkg::K3_COEF);
                coef_im = '0;
            end
            r6tb_pkg::OP_X0: begin
                coef_re = CW'(r6tb_pkg::ONE_COEF);
                coef_im = '0;
            end
            default: begin
                coef_re = CW'($signed(r_twr[tw_rd_idx]));
                coef_im = CW'($signed(r_twi[tw_rd_idx]));
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_op      = r_op;
        n_issuing = r_issuing;
        unique case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    if (r_cnt == LAST_POINT) begin
                        n_cnt   = 3'd0;
                        n_state = ST_BFLY;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            ST_BFLY: begin
                n_state   = ST_EXEC;
                n_op      = r6tb_pkg::OP_K3A;
                n_issuing = 1'b1;
            end
            ST_EXEC: begin
                if (advance) begin
                    if (r_op == r6tb_pkg::OP_X5) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_op = r_op + 3'd1;
                    end
                end
                if (take && (mul_tag.op == r6tb_pkg::OP_X5)) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= 3'd0;
            r_op      <= r6tb_pkg::OP_K3A;
            r_issuing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_op      <= n_op;
            r_issuing <= n_issuing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re   <= sat_re;
            r_out_im   <= sat_im;
            r_out_idx  <= mul_tag.op - r6tb_pkg::OP_X0;
            r_out_last <= (mul_tag.op == r6tb_pkg::OP_X5);
        end
    end

    r6tb_bfly #(
        .SW (SAMPLE_WIDTH)
    ) u_bfly (
        .i_clk    (i_clk),
        .i_load   (r_state == ST_BFLY),
        .i_xr     (r_xr),
        .i_xi     (r_xi),
        .i_k3_tag (k3_tag),
        .i_k3_re  (short_re),
        .i_k3_im  (short_im),
        .i_op     (r_op),
        .o_opa    (opa),
        .o_opb    (opb)
    );

    r6tb_cmul #(
        .DW (DW),
        .CW (CW)
    ) u_cmul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_opa      (opa),
        .i_opb      (opb),
        .i_wr       (coef_re),
        .i_wi       (coef_im),
        .i_take     (take),
        .o_tag      (mul_tag),
        .o_short_re (short_re),
        .o_short_im (short_im),
        .o_sat_re   (sat_re),
        .o_sat_im   (sat_im)
    );

    assign o_out_valid = r_out_valid;
    assign o_bin_re    = r_out_re;
    assign o_bin_im    = r_out_im;
    assign o_out_index = r_out_idx;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/core/r6tb_checker.sv -----
// ----------------------------------------------------------------------------
// r6tb_checker
// Port-level checks of the radix-6 butterfly: output order, end-of-group
// flag, output hold under stall and input stall during emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module r6tb_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic [r6tb_pkg::OUT_WIDTH-1:0]      o_bin_re,
    input wire logic [r6tb_pkg::OUT_WIDTH-1:0]      o_bin_im,
    input wire logic [r6tb_pkg::IDX_WIDTH-1:0]      o_out_index,
    input wire logic                                o_last
);

    logic [r6tb_pkg::IDX_WIDTH-1:0] r_next_idx;

    // Track the index the next output beat must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_idx <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_next_idx <= o_last ? '0 : o_out_index + 3'd1;
        end
    end

    `ASSERT_STD(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bin_re) && $stable(o_bin_im) && $stable(o_out_index), "stalled output beat changed")
    `ASSERT_STD(a_out_order, o_out_valid |-> (o_out_index == r_next_idx), "output index out of order")
    `ASSERT_STD(a_last_flag, o_out_valid |-> (o_last == (o_out_index == r6tb_pkg::LAST_INDEX)), "last flag does not match index")
    `ASSERT_STD(a_in_held, o_out_valid && !o_last |-> o_in_stall, "input taken before group finished")

endmodule

bind radix6_c2r_twiddle_butterfly r6tb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_bin_re    (o_bin_re),
    .o_bin_im    (o_bin_im),
    .o_out_index (o_out_index),
    .o_last      (o_last)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the radix-6 twiddle butterfly against a behavioral predictor. Groups
// of six samples go in, one beat per sample, with twiddles for outputs 1..5.
// Directed groups cover the sample extremes, conjugation of the most negative
// sample, out-of-range twiddles, the ignored point-0 twiddle and output
// saturation. Random groups follow under several idle and stall mixes. Every
// output beat is compared field by field with the oldest predicted bin.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_WIDTH = r6tb_pkg::OUT_WIDTH;
    localparam int IDX_WIDTH = r6tb_pkg::IDX_WIDTH;
    localparam int FRAC_BITS = r6tb_pkg::FRAC_BITS;
    localparam int K3_COEF   = r6tb_pkg::K3_COEF;
    localparam int ONE_COEF  = r6tb_pkg::ONE_COEF;
    localparam logic [r6tb_pkg::IDX_WIDTH-1:0] LAST_INDEX = r6tb_pkg::LAST_INDEX;

    localparam int SW            = 24;
    localparam int TW            = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int GROUPS_PER_PHASE = 17;
    localparam int MAX_REPORTS   = 60;

    localparam longint SAT_HI = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (OUT_WIDTH - 1));
    localparam longint ROUND_BIAS = longint'(1) <<< (FRAC_BITS - 1);

    typedef logic signed [SW-1:0] t_smp;
    typedef logic signed [TW-1:0] t_twd;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] re;
        logic signed [OUT_WIDTH-1:0] im;
        logic [IDX_WIDTH-1:0]        idx;
        logic                        lst;
    } t_spectral_bin;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_smp i_sample_real = '0;
    t_smp i_sample_imag = '0;
    t_twd i_twiddle_real = '0;
    t_twd i_twiddle_imag = '0;

    logic                        o_in_stall;
    logic                        o_out_valid;
    logic signed [OUT_WIDTH-1:0] o_bin_re;
    logic signed [OUT_WIDTH-1:0] o_bin_im;
    logic [IDX_WIDTH-1:0]        o_out_index;
    logic                        o_last;

    radix6_c2r_twiddle_butterfly #(
        .SAMPLE_WIDTH  (SW),
        .TWIDDLE_WIDTH (TW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_real  (i_sample_real),
        .i_sample_imag  (i_sample_imag),
        .i_twiddle_real (i_twiddle_real),
        .i_twiddle_imag (i_twiddle_imag),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_re       (o_bin_re),
        .o_bin_im       (o_bin_im),
        .o_out_index    (o_out_index),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: captured points (conjugated for 3..5) and twiddles
    longint        pt_re [6];
    longint        pt_im [6];
    longint        tw_re [6];
    longint        tw_im [6];
    int unsigned   point_idx = 0;
    t_spectral_bin expected_bins[$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int quiet_cycles  = 0;

    function automatic longint round_q16(input longint x);
        return (x + ROUND_BIAS) >>> FRAC_BITS;
    endfunction

    function automatic longint mul_half(input longint x);
        return round_q16(x * ROUND_BIAS);
    endfunction

    function automatic longint mul_k3(input longint x);
        return round_q16(x * K3_COEF);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input longint x);
        if (x > SAT_HI) x = SAT_HI;
        if (x < SAT_LO) x = SAT_LO;
        return x[OUT_WIDTH-1:0];
    endfunction

    task automatic push_bin(input int k, input longint re, input longint im);
        t_spectral_bin b;
        longint        wr;
        longint        wi;
        wr = tw_re[k];
        wi = tw_im[k];
        if (k == 0) begin
            b.re = clamp_out(re);
            b.im = clamp_out(im);
        end else begin
            b.re = clamp_out(round_q16(re * wr - im * wi));
            b.im = clamp_out(round_q16(re * wi + im * wr));
        end
        b.idx = k[IDX_WIDTH-1:0];
        b.lst = (b.idx == LAST_INDEX);
        expected_bins.push_back(b);
    endtask

    task automatic compute_spectrum;
        longint s03r, s03i, s15r, s15i, s24r, s24i;
        longint d03r, d03i, d15r, d15i, d24r, d24i;
        longint ddr, ddi, ssr, ssi;
        longint t1r, t1i, t2r, t2i, u1r, u1i, u2r, u2i;
        s03r = pt_re[0] + pt_re[3];  s03i = pt_im[0] + pt_im[3];
        s15r = pt_re[1] + pt_re[5];  s15i = pt_im[1] + pt_im[5];
        s24r = pt_re[2] + pt_re[4];  s24i = pt_im[2] + pt_im[4];
        d03r = pt_re[0] - pt_re[3];  d03i = pt_im[0] - pt_im[3];
        d15r = pt_re[1] - pt_re[5];  d15i = pt_im[1] - pt_im[5];
        d24r = pt_re[2] - pt_re[4];  d24i = pt_im[2] - pt_im[4];
        ddr  = s24r - s15r;          ddi  = s24i - s15i;
        ssr  = s24r + s15r;          ssi  = s24i + s15i;

        t1r = d03r - mul_half(ddr);
        t1i = mul_k3(d15i + d24i);
        t2i = d03i - mul_half(ddi);
        t2r = mul_k3(d24r + d15r);
        u1r = s03r - mul_half(ssr);
        u1i = mul_k3(d15i - d24i);
        u2i = s03i - mul_half(ssi);
        u2r = mul_k3(d24r - d15r);

        push_bin(0, s03r + ssr, s03i + ssi);
        push_bin(1, t1r - t1i, t2i + t2r);
        push_bin(2, u1r - u1i, u2i - u2r);
        push_bin(3, d03r + ddr, d03i + ddi);
        push_bin(4, u1r + u1i, u2i + u2r);
        push_bin(5, t1r + t1i, t2i - t2r);
    endtask

    task automatic capture_point(input t_smp sr, input t_smp si, input t_twd tr,
                                 input t_twd ti);
        pt_re[point_idx] = sr;
        // conjugate the upper half; the most negative value stays exact here
        pt_im[point_idx] = (point_idx >= 3) ? -longint'(si) : longint'(si);
        if (point_idx >= 1) begin
            tw_re[point_idx] = tr;
            tw_im[point_idx] = ti;
        end
        if (point_idx < 5) begin
            point_idx++;
        end else begin
            point_idx = 0;
            compute_spectrum();
        end
    endtask

    task automatic send_beat(input t_smp sr, input t_smp si, input t_twd tr,
                             input t_twd ti);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_sample_real  <= sr;
        i_sample_imag  <= si;
        i_twiddle_real <= tr;
        i_twiddle_imag <= ti;
        do @(posedge i_clk); while (o_in_stall);
        capture_point(sr, si, tr, ti);
    endtask

    task automatic send_group(input int sr[6], input int si[6], input int tr[6],
                              input int ti[6]);
        for (int n = 0; n < 6; n++)
            send_beat(t_smp'(sr[n]), t_smp'(si[n]), t_twd'(tr[n]), t_twd'(ti[n]));
    endtask

    function automatic t_smp rand_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return '0;
            3:       return t_smp'($urandom_range(0, 512)) - t_smp'(256);
            default: return t_smp'($urandom);
        endcase
    endfunction

    function automatic t_twd rand_twiddle();
        case ($urandom_range(0, 9))
            8:       return t_twd'($urandom);
            9:       return $urandom_range(0, 1) ? t_twd'(ONE_COEF) : -t_twd'(ONE_COEF);
            default: return t_twd'($urandom_range(0, 2 * ONE_COEF)) - t_twd'(ONE_COEF);
        endcase
    endfunction

    task automatic send_random_groups(input int n_groups);
        for (int g = 0; g < n_groups; g++)
            for (int n = 0; n < 6; n++)
                send_beat(rand_sample(), rand_sample(), rand_twiddle(), rand_twiddle());
    endtask

    // Hold the sender until every predicted bin has come out, then let it settle
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_extremes;
        int pmax;
        int nmin;
        int sr[6];
        int si[6];
        int tr[6];
        int ti[6];
        pmax = 8388607;
        nmin = -8388608;
        send_idle_pct = 0;
        out_stall_pct = 0;
        // full-scale positive, identity twiddles, point-0 twiddle must be ignored
        sr = '{pmax, pmax, pmax, pmax, pmax, pmax};
        tr = '{-ONE_COEF, ONE_COEF, ONE_COEF, ONE_COEF, ONE_COEF, ONE_COEF};
        ti = '{ONE_COEF, 0, 0, 0, 0, 0};
        send_group(sr, sr, tr, ti);
        // most negative everywhere; conjugation gives +2^23 on points 3..5
        sr = '{nmin, nmin, nmin, nmin, nmin, nmin};
        tr = '{12345, -ONE_COEF, ONE_COEF, 0, -ONE_COEF, 0};
        ti = '{-999, -ONE_COEF, ONE_COEF, ONE_COEF, 0, -ONE_COEF};
        send_group(sr, sr, tr, ti);
        // alternating signs load X3; out-of-range twiddles drive it to saturation
        sr = '{pmax, nmin, pmax, nmin, pmax, nmin};
        si = '{pmax, nmin, pmax, pmax, nmin, pmax};
        tr = '{0, -131072, 131071, 131071, -131072, 1};
        ti = '{0, 131071, 131071, -131072, -131072, -1};
        send_group(sr, si, tr, ti);
        tr = '{0, 131071, -131072, -131072, 131071, -1};
        ti = '{0, -131072, -131072, -131072, 131071, 1};
        send_group(sr, si, tr, ti);
        wait_drained();
    endtask

    task automatic test_back_to_back;
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_random_groups(GROUPS_PER_PHASE);
        wait_drained();
    endtask

    task automatic test_sender_gaps;
        send_idle_pct = 61;
        out_stall_pct = 0;
        send_random_groups(GROUPS_PER_PHASE);
        wait_drained();
    endtask

    task automatic test_receiver_stall;
        send_idle_pct = 0;
        out_stall_pct = 61;
        send_random_groups(GROUPS_PER_PHASE);
        wait_drained();
    endtask

    task automatic test_light_both;
        send_idle_pct = 7;
        out_stall_pct = 7;
        send_random_groups(GROUPS_PER_PHASE);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_spectral_bin b;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bins.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected output beat idx=%0d re=%0d im=%0d",
                             $time, o_out_index, o_bin_re, o_bin_im);
            end else begin
                b = expected_bins.pop_front();
                if (o_bin_re !== b.re) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: bin_re idx %0d expected %0d actual %0d",
                                 $time, b.idx, b.re, o_bin_re);
                end
                if (o_bin_im !== b.im) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: bin_im idx %0d expected %0d actual %0d",
                                 $time, b.idx, b.im, o_bin_im);
                end
                if (o_out_index !== b.idx) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, b.idx, o_out_index);
                end
                if (o_last !== b.lst) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: last idx %0d expected %0b actual %0b",
                                 $time, b.idx, b.lst, o_last);
                end
            end
        end
    end

    // Count cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired, %0d bins outstanding",
                     $time, expected_bins.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stall();
        test_light_both();

        if (expected_bins.size() != 0) begin
            err_count++;
            $display("%0t: %0d predicted bins never arrived", $time, expected_bins.size());
        end
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
